### hdl/assert_macros.svh
// Assertion macros for the RTL; they expect clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset masked.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, reset masked.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### hdl/hcs_pkg.sv
// Package for the HTML markup context scanner: context codes, byte codes, step result type, blank test.
package hcs_pkg;

  typedef logic [3:0] ctx_t;
  typedef logic [7:0] byte_t;

  localparam ctx_t CTX_INIT      = 4'd0;
  localparam ctx_t CTX_TEXT      = 4'd1;
  localparam ctx_t CTX_TAG       = 4'd2;
  localparam ctx_t CTX_OPEN      = 4'd3;
  localparam ctx_t CTX_BANG      = 4'd4;
  localparam ctx_t CTX_BANG_DASH = 4'd5;
  localparam ctx_t CTX_COMMENT   = 4'd6;
  localparam ctx_t CTX_CDASH     = 4'd7;
  localparam ctx_t CTX_CDASH2    = 4'd8;
  localparam ctx_t CTX_UNQ       = 4'd9;
  localparam ctx_t CTX_UNQ_ESC   = 4'd10;
  localparam ctx_t CTX_VSTART    = 4'd11;
  localparam ctx_t CTX_SQ        = 4'd12;
  localparam ctx_t CTX_SQ_ESC    = 4'd13;
  localparam ctx_t CTX_DQ        = 4'd14;
  localparam ctx_t CTX_DQ_ESC    = 4'd15;

  localparam byte_t CH_GT    = 8'h3E;
  localparam byte_t CH_LT    = 8'h3C;
  localparam byte_t CH_EQ    = 8'h3D;
  localparam byte_t CH_BANG  = 8'h21;
  localparam byte_t CH_DASH  = 8'h2D;
  localparam byte_t CH_SQUOT = 8'h27;
  localparam byte_t CH_DQUOT = 8'h22;
  localparam byte_t CH_BSL   = 8'h5C;
  localparam byte_t CH_SP    = 8'h20;
  localparam byte_t CH_HT    = 8'h09;
  localparam byte_t CH_LF    = 8'h0A;
  localparam byte_t CH_VT    = 8'h0B;
  localparam byte_t CH_FF    = 8'h0C;
  localparam byte_t CH_CR    = 8'h0D;

  typedef struct packed {
    logic mark;
    logic suppress;
    ctx_t ctx;
  } step_t;

  function automatic logic is_space(input byte_t c);
    return (c == CH_SP) || (c == CH_HT) || (c == CH_LF) || (c == CH_VT) ||
           (c == CH_FF) || (c == CH_CR);
  endfunction

endpackage

### hdl/hcs_step.sv
// Next-context and pass-mark logic for one byte.
module hcs_step (
  input  hcs_pkg::ctx_t  ctx,
  input  logic           suppress,
  input  hcs_pkg::byte_t ch,
  output hcs_pkg::step_t res
);
  import hcs_pkg::*;

  ctx_t base;
  logic delim;

  always_comb begin
    res.mark     = ~suppress;
    res.suppress = suppress;
    res.ctx      = ctx;
    base         = ctx;
    delim        = 1'b0;
    unique case (ctx) inside
      CTX_INIT, CTX_TEXT: begin
        if (ch == CH_LT) begin
          res.suppress = 1'b1;
          res.ctx      = CTX_OPEN;
        end
      end
      CTX_TAG, CTX_OPEN, CTX_BANG, CTX_BANG_DASH: begin
        if (ch == CH_GT) begin
          res.ctx = CTX_TEXT;
        end else if (ch == CH_EQ) begin
          res.ctx = CTX_VSTART;
        end else if (ctx == CTX_OPEN) begin
          res.ctx = (ch == CH_BANG) ? CTX_BANG : CTX_TAG;
        end else if (ctx == CTX_BANG) begin
          res.ctx = (ch == CH_DASH) ? CTX_BANG_DASH : CTX_TAG;
        end else if (ctx == CTX_BANG_DASH) begin
          res.ctx = (ch == CH_DASH) ? CTX_COMMENT : CTX_TAG;
        end
      end
      CTX_COMMENT: begin
        if (ch == CH_DASH) res.ctx = CTX_CDASH;
      end
      CTX_CDASH: begin
        res.ctx = (ch == CH_DASH) ? CTX_CDASH2 : CTX_COMMENT;
      end
      CTX_CDASH2: begin
        if (ch == CH_GT) begin
          res.ctx = CTX_TEXT;
        end else if (ch != CH_DASH) begin
          res.ctx = CTX_COMMENT;
        end
      end
      CTX_UNQ, CTX_VSTART, CTX_SQ, CTX_DQ: begin
        res.mark     = 1'b1;
        res.suppress = 1'b0;
        if (ctx == CTX_VSTART) begin
          if (ch == CH_SQUOT) begin
            base = CTX_SQ;
          end else if (ch == CH_DQUOT) begin
            base = CTX_DQ;
          end else begin
            base = CTX_UNQ;
          end
        end
        // delimiter is judged on the context before the value start resolves
        if (ctx == CTX_SQ) begin
          delim = (ch == CH_SQUOT);
        end else if (ctx == CTX_DQ) begin
          delim = (ch == CH_DQUOT);
        end else begin
          delim = is_space(ch) || (ch == CH_GT);
        end
        if (ch == CH_BSL) begin
          res.ctx = ctx_t'(base + ctx_t'(1));
        end else if (delim) begin
          res.ctx = CTX_TAG;
        end else begin
          res.ctx = base;
        end
      end
      CTX_UNQ_ESC: res.ctx = CTX_UNQ;
      CTX_SQ_ESC:  res.ctx = CTX_SQ;
      CTX_DQ_ESC:  res.ctx = CTX_DQ;
    endcase
  end

endmodule

### hdl/html_markup_context_scanner_top.sv
// Top level of the HTML markup context scanner: input register, context state, result register.
//
// Usage:
//   Input channel: in_valid / in_stall carry one HTML byte (char_byte) per item.
//   Output channel: out_valid / out_stall carry one result item per byte:
//     pass_mark (byte is significant) and context_after (context code after it).
//   An item moves on a rising edge with valid high and stall low.
// Path: an accepted byte is shown on the output after a two-register path
//   (input register, then result register).
// Throughput: one item per cycle while out_stall is low; the 4-bit context
//   and suppress flag are updated by a single combinational step as the
//   item moves into the result register, so consecutive bytes flow without a gap.
// Stall: when out_stall holds a waiting result, the input register still
//   takes one more item; in_stall rises only when both registers are full
//   and the output is stalled.
// Reset (rst, synchronous, active high): both registers empty, context set
//   to the initial code, suppress flag set.
module html_markup_context_scanner_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  hcs_pkg::byte_t char_byte,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           pass_mark,
  output hcs_pkg::ctx_t  context_after
);
  import hcs_pkg::*;
  `include "assert_macros.svh"

  // input register
  logic  hold_valid;
  byte_t hold_byte;

  // scanner state
  ctx_t  ctx_code;
  logic  suppress_flag;

  step_t step_res;
  logic  advance;

  hcs_step u_step (
    .ctx      (ctx_code),
    .suppress (suppress_flag),
    .ch       (hold_byte),
    .res      (step_res)
  );

  // held item moves to the result register when that register is free or draining
  assign advance  = hold_valid && (!out_valid || !out_stall);
  assign in_stall = hold_valid && out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_byte <= char_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx_code      <= CTX_INIT;
      suppress_flag <= 1'b1;
    end else if (advance) begin
      ctx_code      <= step_res.ctx;
      suppress_flag <= step_res.suppress;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pass_mark     <= step_res.mark;
      context_after <= step_res.ctx;
    end
  end

  // a shown result always carries the current context
  `ASSERT_IMPL(a_ctx_match, out_valid, context_after == ctx_code)
  // the initial context is never re-entered once left
  `ASSERT_NEXT(a_init_once, ctx_code != CTX_INIT, ctx_code != CTX_INIT)
  // value and escape contexts are reached only through value handling
  `ASSERT_IMPL(a_value_unsuppressed,
    ctx_code == CTX_UNQ || ctx_code == CTX_UNQ_ESC || ctx_code == CTX_SQ ||
    ctx_code == CTX_SQ_ESC || ctx_code == CTX_DQ || ctx_code == CTX_DQ_ESC,
    !suppress_flag)
  // a moved item shows up on the output next cycle
  `ASSERT_NEXT(a_advance_shows, advance, out_valid)

endmodule

### test/hcs_scan_checker.sv
// Checker for the HTML context scanner: predicts each byte's result and compares it.
`timescale 1ns / 1ps

module hcs_scan_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_stall,
  input  hcs_pkg::byte_t char_byte,
  input  logic           out_valid,
  input  logic           out_stall,
  input  logic           pass_mark,
  input  hcs_pkg::ctx_t  context_after,
  output int             fail_count,
  output int             pending,
  output int             checked,
  output logic [15:0]    ctx_seen
);
  import hcs_pkg::*;

  typedef struct packed {
    logic mark;
    ctx_t ctx;
  } scan_result_t;

  scan_result_t predicted_results[$];

  // scanner state as the block should hold it
  ctx_t scan_ctx;
  logic scan_suppress;

  function automatic logic html_blank(input byte_t c);
    case (c)
      CH_SP, CH_HT, CH_LF, CH_VT, CH_FF, CH_CR: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // one byte through the context machine
  task automatic scan_byte(input byte_t c, output scan_result_t res);
    ctx_t cur;
    ctx_t nxt;
    logic mark;
    logic delim;
    cur = scan_ctx;
    nxt = cur;
    mark = !scan_suppress;
    case (cur)
      CTX_INIT, CTX_TEXT: begin
        if (c == CH_LT) begin
          scan_suppress = 1'b1;
          nxt = CTX_OPEN;
        end
      end
      CTX_TAG, CTX_OPEN, CTX_BANG, CTX_BANG_DASH: begin
        if (c == CH_GT) nxt = CTX_TEXT;
        else if (c == CH_EQ) nxt = CTX_VSTART;
        else if (cur == CTX_OPEN) nxt = (c == CH_BANG) ? CTX_BANG : CTX_TAG;
        else if (cur == CTX_BANG) nxt = (c == CH_DASH) ? CTX_BANG_DASH : CTX_TAG;
        else if (cur == CTX_BANG_DASH) nxt = (c == CH_DASH) ? CTX_COMMENT : CTX_TAG;
      end
      CTX_COMMENT: begin
        if (c == CH_DASH) nxt = CTX_CDASH;
      end
      CTX_CDASH: nxt = (c == CH_DASH) ? CTX_CDASH2 : CTX_COMMENT;
      CTX_CDASH2: begin
        if (c == CH_GT) nxt = CTX_TEXT;
        else if (c != CH_DASH) nxt = CTX_COMMENT;
      end
      CTX_UNQ, CTX_VSTART, CTX_SQ, CTX_DQ: begin
        mark = 1'b1;
        scan_suppress = 1'b0;
        if (cur == CTX_VSTART) begin
          if (c == CH_SQUOT) nxt = CTX_SQ;
          else if (c == CH_DQUOT) nxt = CTX_DQ;
          else nxt = CTX_UNQ;
        end
        if (c == CH_BSL) begin
          case (nxt)
            CTX_SQ: nxt = CTX_SQ_ESC;
            CTX_DQ: nxt = CTX_DQ_ESC;
            default: nxt = CTX_UNQ_ESC;
          endcase
        end else begin
          // delimiter is judged on the context before the value start resolved
          if (cur == CTX_SQ) delim = (c == CH_SQUOT);
          else if (cur == CTX_DQ) delim = (c == CH_DQUOT);
          else delim = html_blank(c) || (c == CH_GT);
          if (delim) nxt = CTX_TAG;
        end
      end
      CTX_UNQ_ESC: nxt = CTX_UNQ;
      CTX_SQ_ESC: nxt = CTX_SQ;
      default: nxt = CTX_DQ;
    endcase
    scan_ctx = nxt;
    res.mark = mark;
    res.ctx = nxt;
  endtask

  always @(posedge clk) begin
    scan_result_t res;
    scan_result_t want;
    if (rst) begin
      predicted_results.delete();
      scan_ctx = CTX_INIT;
      scan_suppress = 1'b1;
      fail_count <= 0;
      checked <= 0;
      ctx_seen <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        scan_byte(char_byte, res);
        predicted_results.push_back(res);
      end
      if (out_valid && !out_stall) begin
        checked <= checked + 1;
        ctx_seen[context_after] <= 1'b1;
        if (predicted_results.size() == 0) begin
          $display("%0t: unexpected result mark=%0b ctx=%0d", $time, pass_mark,
                   context_after);
          fail_count <= fail_count + 1;
        end else begin
          want = predicted_results.pop_front();
          if (pass_mark !== want.mark || context_after !== want.ctx) begin
            if (pass_mark !== want.mark)
              $display("%0t: pass_mark expected %0b actual %0b", $time, want.mark,
                       pass_mark);
            if (context_after !== want.ctx)
              $display("%0t: context_after expected %0d actual %0d", $time, want.ctx,
                       context_after);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    // items still waiting for their result
    pending <= predicted_results.size();
  end

endmodule

### test/tb.sv
// Testbench top for the HTML context scanner: stimulus, stall patterns and verdict.
`timescale 1ns / 1ps

module tb;
  import hcs_pkg::*;

  localparam int RANDOM_BYTES = 1700;
  // worst case is far below this: random gaps between bursts, heavy output stall
  localparam int CYCLE_LIMIT  = 400000;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_stall;
  byte_t char_byte = 8'h00;
  logic  out_valid;
  logic  out_stall = 1'b0;
  logic  pass_mark;
  ctx_t  context_after;

  int fail_count;
  int pending;
  int checked;
  logic [15:0] ctx_seen;

  int bytes_sent = 0;
  int directed_sent = 0;
  int burst_left = 0;
  int cycles = 0;

  always #4 clk = ~clk;

  html_markup_context_scanner_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .char_byte    (char_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pass_mark    (pass_mark),
    .context_after(context_after)
  );

  hcs_scan_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .char_byte    (char_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pass_mark    (pass_mark),
    .context_after(context_after),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked),
    .ctx_seen     (ctx_seen)
  );

  // Hard stop: a hung handshake or a lost result lands here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Output stall: phases of random length, each with its own pattern
  // (free flowing, light random, heavy random, periodic).
  int stall_mode = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((cycles % 5) < 2);
    endcase
  end

  // Hand one byte over. Bursts of random length, random gaps between them.
  // in_stall is sampled at the falling edge, so the decision does not race
  // with the block's own update at the rising edge.
  task automatic send_byte(input byte_t b);
    int gap;
    logic stalled;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    in_valid <= 1'b1;
    char_byte <= b;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    burst_left--;
    bytes_sent++;
  endtask

  // Stop sending until every predicted result has come out.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  function automatic byte_t rand_any();
    return byte_t'($urandom_range(0, 255));
  endfunction

  function automatic byte_t rand_letter();
    return byte_t'($urandom_range(8'h61, 8'h7A));
  endfunction

  function automatic byte_t rand_blank();
    case ($urandom_range(0, 5))
      0: return CH_SP;
      1: return CH_HT;
      2: return CH_LF;
      3: return CH_VT;
      4: return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  // Plain text between tags; '<' would open a tag, so it is swapped out.
  task automatic send_text();
    int n;
    int r;
    byte_t b;
    n = $urandom_range(1, 8);
    repeat (n) begin
      r = $urandom_range(0, 9);
      if (r < 6) b = rand_letter();
      else if (r < 8) b = rand_blank();
      else b = rand_any();
      if (b == CH_LT) b = rand_letter();
      send_byte(b);
    end
  endtask

  // Attribute value right after '='. All three kinds carry escapes and
  // arbitrary bytes; the closing delimiter is sometimes left out.
  task automatic send_value();
    int kind;
    int n;
    int r;
    byte_t quote;
    byte_t b;
    kind = $urandom_range(0, 2);
    quote = (kind == 1) ? CH_SQUOT : CH_DQUOT;
    if (kind != 0) send_byte(quote);
    n = $urandom_range(0, 8);
    repeat (n) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        send_byte(CH_BSL);
        send_byte(($urandom_range(0, 2) == 0) ? quote : rand_any());
      end else begin
        b = (r < 7) ? rand_letter() : rand_any();
        if (kind != 0 && b == quote) b = rand_letter();
        if (kind == 0 && (b == CH_GT || b == CH_BSL || b == CH_SQUOT || b == CH_DQUOT))
          b = rand_letter();
        send_byte(b);
      end
    end
    if ($urandom_range(0, 7) != 0) begin
      if (kind != 0) send_byte(quote);
      else send_byte(($urandom_range(0, 2) == 0) ? CH_GT : rand_blank());
    end
  endtask

  // Tag with a name and a few attributes; the closing '>' is mostly there.
  task automatic send_tag();
    int n;
    send_byte(CH_LT);
    repeat ($urandom_range(1, 5)) send_byte(rand_letter());
    n = $urandom_range(0, 3);
    repeat (n) begin
      send_byte(rand_blank());
      repeat ($urandom_range(1, 4)) send_byte(rand_letter());
      if ($urandom_range(0, 4) == 0) send_byte(rand_blank());
      if ($urandom_range(0, 5) != 0) begin
        send_byte(CH_EQ);
        send_value();
      end
    end
    if ($urandom_range(0, 7) != 0) send_byte(CH_GT);
  endtask

  // "<!--" ... "-->" with dash runs inside; some openings are broken.
  task automatic send_comment();
    int n;
    byte_t b;
    send_byte(CH_LT);
    send_byte(CH_BANG);
    if ($urandom_range(0, 4) == 0) begin
      send_byte(($urandom_range(0, 1) == 0) ? CH_DASH : rand_letter());
      send_byte(rand_any());
    end else begin
      send_byte(CH_DASH);
      send_byte(CH_DASH);
      n = $urandom_range(0, 10);
      repeat (n) begin
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) send_byte(CH_DASH);
          b = rand_any();
          if (b == CH_GT) b = rand_letter();
          send_byte(b);
        end else begin
          send_byte(rand_any());
        end
      end
      if ($urandom_range(0, 5) != 0) begin
        send_byte(CH_DASH);
        send_byte(CH_DASH);
        send_byte(CH_GT);
      end
    end
  endtask

  initial begin
    bit drained;
    drained = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero and all-ones bytes in the initial context, the full
    // "<!-----" dash walk and comment close, an escaped unquoted value with a
    // zero byte inside, escaped quotes in both quoted forms, and '>' that does
    // not end a double-quoted value.
    send_byte(8'h00);    send_byte(8'hFF);
    send_byte(CH_LT);    send_byte(CH_BANG);  send_byte(CH_DASH);
    send_byte(CH_DASH);  send_byte(CH_DASH);  send_byte(CH_DASH);
    send_byte(CH_DASH);  send_byte(CH_GT);
    send_byte(CH_LT);    send_byte(CH_EQ);    send_byte(CH_BSL);
    send_byte(8'h78);    send_byte(8'h00);    send_byte(CH_SP);
    send_byte(CH_EQ);    send_byte(CH_SQUOT); send_byte(CH_BSL);
    send_byte(CH_SQUOT); send_byte(CH_SQUOT);
    send_byte(CH_EQ);    send_byte(CH_DQUOT); send_byte(CH_BSL);
    send_byte(CH_DQUOT); send_byte(CH_GT);    send_byte(CH_DQUOT);
    send_byte(CH_GT);
    directed_sent = bytes_sent;

    // Random: mostly well-formed markup, some raw noise.
    while (bytes_sent - directed_sent < RANDOM_BYTES) begin
      case ($urandom_range(0, 9))
        0, 1, 2: send_text();
        3, 4, 5, 6: send_tag();
        7, 8: send_comment();
        default: repeat ($urandom_range(1, 8)) send_byte(rand_any());
      endcase
      // one full drain in the middle of the run
      if (!drained && bytes_sent - directed_sent >= RANDOM_BYTES / 2) begin
        drain();
        drained = 1;
      end
    end

    drain();
    // catch any stray result after the last expected one
    repeat (20) @(posedge clk);

    $display("Scanned %0d bytes (%0d directed), %0d results checked.", bytes_sent,
             directed_sent, checked);
    $display("Context codes reached: %0d of 16.", $countones(ctx_seen));
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
